### rtl/core/rrsa_pkg.sv
// shared types and constants of the round-robin slot allocator
package rrsa_pkg;

    // field widths of the request and the result
    localparam int OP_W       = 3;
    localparam int SLOT_W_IN  = 8;
    localparam int CLIENT_W   = 8;
    localparam int STATUS_W   = 3;
    localparam int GRANT_W    = 3;
    localparam int CFG_W      = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    // request field offsets inside tdata
    localparam int OP_LSB     = 0;
    localparam int SLOT_LSB   = OP_LSB + OP_W;
    localparam int CLIENT_LSB = SLOT_LSB + SLOT_W_IN;

    // slot count after reset
    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 4'd8;

    // request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_OPEN        = 3'd0,
        OP_CLOSE       = 3'd1,
        OP_CHECK_START = 3'd2,
        OP_MARK_BUSY   = 3'd3,
        OP_CHECK_STOP  = 3'd4,
        OP_MARK_IDLE   = 3'd5
    } op_code_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_FULL         = 3'd1,
        ST_INVALID      = 3'd2,
        ST_NOT_OWNER    = 3'd3,
        ST_ALREADY_BUSY = 3'd4,
        ST_NOT_BUSY     = 3'd5,
        ST_BUSY_CLOSE   = 3'd6
    } status_t;

    // request class as seen by the back end
    typedef enum logic [2:0] {
        CLS_OPEN,
        CLS_CLOSE,
        CLS_CHECK_START,
        CLS_CHECK_STOP,
        CLS_MARK_BUSY,
        CLS_MARK_IDLE,
        CLS_INVALID
    } cmd_class_t;

    // classified request held in the queue
    typedef struct packed {
        cmd_class_t            cls;
        logic [SLOT_W_IN-1:0]  slot;
        logic [CLIENT_W-1:0]   client;
    } cmd_t;

    // queue head seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_READ
    } back_state_t;

endpackage

### rtl/core/rrsa_ram.sv
// generic single write port ram with registered read
module rrsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/rrsa_queue.sv
// two-entry request queue between front and back end
module rrsa_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  rrsa_pkg::cmd_t        push_cmd,
    output rrsa_pkg::queue_head_t head,
    input  logic                  pop
);

    rrsa_pkg::cmd_t entry_reg [2];
    logic [1:0]     count_reg, count_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/rrsa_front.sv
// front end: request intake, slot count register and request classification
module rrsa_front #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [rrsa_pkg::IN_DATA_W-1:0]              s_tdata,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [rrsa_pkg::CFG_W-1:0]                  cfg_data,
    output logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1):0] active_count,
    output logic                                        push_valid,
    input  logic                                        push_ready,
    output rrsa_pkg::cmd_t                              push_cmd
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = SLOT_W + 1;

    logic [rrsa_pkg::CFG_W-1:0]     slots_in_use_reg;
    logic [rrsa_pkg::OP_W-1:0]      op;
    logic [rrsa_pkg::SLOT_W_IN-1:0] slot;
    logic [rrsa_pkg::CLIENT_W-1:0]  client;
    logic [CNT_W-1:0]               n;
    logic                           in_range;
    rrsa_pkg::cmd_class_t           cls;

    // slot count register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= rrsa_pkg::SLOTS_IN_USE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            slots_in_use_reg <= cfg_data;
        end
    end

    // clamp the slot count to 1 .. MAX_SLOTS
    always_comb
    begin
        if (slots_in_use_reg == '0)
        begin
            n = CNT_W'(1);
        end
        else if (32'(slots_in_use_reg) > 32'(MAX_SLOTS))
        begin
            n = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            n = CNT_W'(slots_in_use_reg);
        end
    end

    assign active_count = n;

    // unpack the request
    assign op     = s_tdata[rrsa_pkg::OP_LSB +: rrsa_pkg::OP_W];
    assign slot   = s_tdata[rrsa_pkg::SLOT_LSB +: rrsa_pkg::SLOT_W_IN];
    assign client = s_tdata[rrsa_pkg::CLIENT_LSB +: rrsa_pkg::CLIENT_W];

    assign in_range = (32'(slot) < 32'(n));

    // opcode decode with range check
    always_comb
    begin
        unique case (op)
            rrsa_pkg::OP_OPEN:        cls = rrsa_pkg::CLS_OPEN;
            rrsa_pkg::OP_CLOSE:       cls = rrsa_pkg::CLS_CLOSE;
            rrsa_pkg::OP_CHECK_START: cls = rrsa_pkg::CLS_CHECK_START;
            rrsa_pkg::OP_MARK_BUSY:   cls = rrsa_pkg::CLS_MARK_BUSY;
            rrsa_pkg::OP_CHECK_STOP:  cls = rrsa_pkg::CLS_CHECK_STOP;
            rrsa_pkg::OP_MARK_IDLE:   cls = rrsa_pkg::CLS_MARK_IDLE;
            default:                  cls = rrsa_pkg::CLS_INVALID;
        endcase
        if (!in_range && (cls != rrsa_pkg::CLS_OPEN))
        begin
            cls = rrsa_pkg::CLS_INVALID;
        end
    end

    // hand the classified request to the queue
    assign push_valid      = s_tvalid;
    assign s_tready        = push_ready;
    assign push_cmd.cls    = cls;
    assign push_cmd.slot   = slot;
    assign push_cmd.client = client;

endmodule

### rtl/core/rrsa_back.sv
// back end: slot table, round-robin scan and result register
module rrsa_back #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1):0] active_count,
    input  rrsa_pkg::queue_head_t                       head,
    output logic                                        pop,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [rrsa_pkg::OUT_DATA_W-1:0]             m_tdata
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = SLOT_W + 1;

    rrsa_pkg::back_state_t state_reg, state_next;
    rrsa_pkg::cmd_t        cmd_reg, cmd_next;
    logic [MAX_SLOTS-1:0]  taken_reg, taken_next;
    logic [MAX_SLOTS-1:0]  busy_reg, busy_next;
    logic [SLOT_W-1:0]     next_slot_reg, next_slot_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [rrsa_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                          out_free;
    logic                          start;
    logic [SLOT_W-1:0]             head_slot;
    logic [SLOT_W-1:0]             cmd_slot;
    logic [CNT_W-1:0]              idx_inc;
    logic [SLOT_W-1:0]             idx_wrap;
    logic                          scan_last;
    logic                          own_ok;
    logic                          ram_we;
    logic [rrsa_pkg::CLIENT_W-1:0] owner_rd;
    rrsa_pkg::status_t             status;
    logic [rrsa_pkg::GRANT_W-1:0]  granted;
    logic                          result_load;

    assign out_free  = !out_valid_reg || m_tready;
    assign start     = (state_reg == rrsa_pkg::BK_IDLE) && head.valid && out_free;
    assign head_slot = head.cmd.slot[SLOT_W-1:0];
    assign cmd_slot  = cmd_reg.slot[SLOT_W-1:0];

    // round-robin step of the scan pointer
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_wrap  = (idx_inc == active_count) ? '0 : idx_inc[SLOT_W-1:0];
    assign scan_last = ((cnt_reg + CNT_W'(1)) == active_count);

    // owner match for the check requests
    assign own_ok = taken_reg[cmd_slot] && (owner_rd == cmd_reg.client);

    // owner store, written on grant, read at the queue head
    rrsa_ram #(
        .WIDTH (rrsa_pkg::CLIENT_W),
        .DEPTH (MAX_SLOTS)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (cmd_reg.client),
        .rd_addr (head_slot),
        .rd_data (owner_rd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrsa_pkg::BK_IDLE:
            begin
                if (start)
                begin
                    case (head.cmd.cls)
                        rrsa_pkg::CLS_OPEN:
                            state_next = rrsa_pkg::BK_SCAN;
                        rrsa_pkg::CLS_CHECK_START, rrsa_pkg::CLS_CHECK_STOP:
                            state_next = rrsa_pkg::BK_READ;
                        default:
                            state_next = rrsa_pkg::BK_IDLE;
                    endcase
                end
            end
            rrsa_pkg::BK_SCAN:
            begin
                if (!taken_reg[idx_reg] || scan_last)
                begin
                    state_next = rrsa_pkg::BK_IDLE;
                end
            end
            rrsa_pkg::BK_READ:
            begin
                state_next = rrsa_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = rrsa_pkg::BK_IDLE;
            end
        endcase
    end

    // table updates and result
    always_comb
    begin
        cmd_next       = cmd_reg;
        taken_next     = taken_reg;
        busy_next      = busy_reg;
        next_slot_next = next_slot_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        status         = rrsa_pkg::ST_OK;
        granted        = '0;
        result_load    = 1'b0;
        unique case (state_reg)
            rrsa_pkg::BK_IDLE:
            begin
                if (start)
                begin
                    pop      = 1'b1;
                    cmd_next = head.cmd;
                    case (head.cmd.cls)
                        rrsa_pkg::CLS_OPEN:
                        begin
                            idx_next = (32'(next_slot_reg) < 32'(active_count)) ?
                                       next_slot_reg : '0;
                            cnt_next = '0;
                        end
                        rrsa_pkg::CLS_CLOSE:
                        begin
                            result_load = 1'b1;
                            if (busy_reg[head_slot])
                            begin
                                status = rrsa_pkg::ST_BUSY_CLOSE;
                            end
                            else
                            begin
                                taken_next[head_slot] = 1'b0;
                                busy_next[head_slot]  = 1'b0;
                            end
                        end
                        rrsa_pkg::CLS_MARK_BUSY:
                        begin
                            result_load          = 1'b1;
                            busy_next[head_slot] = 1'b1;
                        end
                        rrsa_pkg::CLS_MARK_IDLE:
                        begin
                            result_load          = 1'b1;
                            busy_next[head_slot] = 1'b0;
                        end
                        rrsa_pkg::CLS_CHECK_START, rrsa_pkg::CLS_CHECK_STOP:
                        begin
                            // owner read is under way
                        end
                        default:
                        begin
                            result_load = 1'b1;
                            status      = rrsa_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            rrsa_pkg::BK_SCAN:
            begin
                if (!taken_reg[idx_reg])
                begin
                    // grant the free slot
                    result_load         = 1'b1;
                    granted             = rrsa_pkg::GRANT_W'(idx_reg);
                    taken_next[idx_reg] = 1'b1;
                    busy_next[idx_reg]  = 1'b0;
                    ram_we              = 1'b1;
                    next_slot_next      = idx_wrap;
                end
                else if (scan_last)
                begin
                    result_load = 1'b1;
                    status      = rrsa_pkg::ST_FULL;
                end
                else
                begin
                    idx_next = idx_wrap;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            rrsa_pkg::BK_READ:
            begin
                result_load = 1'b1;
                if (!own_ok)
                begin
                    status = rrsa_pkg::ST_NOT_OWNER;
                end
                else if (cmd_reg.cls == rrsa_pkg::CLS_CHECK_START)
                begin
                    status = busy_reg[cmd_slot] ? rrsa_pkg::ST_ALREADY_BUSY : rrsa_pkg::ST_OK;
                end
                else
                begin
                    status = busy_reg[cmd_slot] ? rrsa_pkg::ST_OK : rrsa_pkg::ST_NOT_BUSY;
                end
            end
            default:
            begin
                status = rrsa_pkg::ST_OK;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (result_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rrsa_pkg::OUT_DATA_W'({granted, status});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrsa_pkg::BK_IDLE;
            taken_reg     <= '0;
            busy_reg      <= '0;
            next_slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            taken_reg     <= taken_next;
            busy_reg      <= busy_next;
            next_slot_reg <= next_slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers without reset
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/core/round_robin_slot_allocator_top.sv
// a close, mark or invalid request passes through a queue entry and the result register;
// a check adds the owner ram read, and an open scans k slots (k = 1 .. n) in the back end
// throughput: one request per cycle for close and marks while the result is taken;
// checks and opens hold the sequencer in its read or scan state; it scans one slot a cycle
// a two-entry queue takes requests while the back end works or a result waits, until full
// reset at once clears taken and busy marks and the scan pointer, sets the slot count to 8
module round_robin_slot_allocator_top #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request: operation [2:0], slot [10:3], client [18:11]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rrsa_pkg::IN_DATA_W-1:0]   s_tdata,
    // result: status [2:0], granted_slot [5:3]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rrsa_pkg::OUT_DATA_W-1:0]  m_tdata,
    // slots_in_use write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rrsa_pkg::CFG_W-1:0]       cfg_data
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = SLOT_W + 1;

    logic [CNT_W-1:0]      active_count;
    logic                  push_valid;
    logic                  push_ready;
    rrsa_pkg::cmd_t        push_cmd;
    rrsa_pkg::queue_head_t head;
    logic                  pop;

    // intake and classification
    rrsa_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .active_count (active_count),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    // request queue
    rrsa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .head       (head),
        .pop        (pop)
    );

    // slot table and sequencer
    rrsa_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .active_count (active_count),
        .head         (head),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

`ifndef SYNTH
    // a failing result never reports a granted slot; only an open grants one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != rrsa_pkg::ST_OK) |-> (m_tdata[5:3] == '0))
    else $error("granted slot set on a failing result");

    // the back end pops only a present queue entry
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
    else $error("pop from an empty request queue");

    // status never takes the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] != 3'd7))
    else $error("result status out of range");

    // the slot count seen by both ends stays within 1 .. MAX_SLOTS
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_count != '0) && (32'(active_count) <= 32'(MAX_SLOTS)))
    else $error("active slot count out of range");
`endif

endmodule
